/* rtl/gf128m_pkg.sv */
// gf128m_pkg: shared constants, stage payload type and field helpers for the
// gf(2^128) multiplier; no dependencies
`default_nettype none

package gf128m_pkg;

	localparam int unsigned FieldBits       = 128;
	localparam int unsigned HalfBits        = 64;
	// x^128 = x^7 + x^2 + x + 1
	localparam logic [FieldBits-1:0] ReducePoly = 128'h87;
	// operand bits consumed per pipeline stage, must divide FieldBits
	localparam int unsigned StepBitsDefault = 8;

	typedef logic [FieldBits-1:0] elem_t;

	// payload carried from stage to stage
	typedef struct packed {
		elem_t a;    // bits of a still to scan, next bit at the top
		elem_t b;
		elem_t acc;  // horner accumulator
	} stage_data_t;

	// multiply by x and fold the carried-out bit back in
	function automatic elem_t gf_double(input elem_t v);
		elem_t r;
		r = {v[FieldBits-2:0], 1'b0};
		if (v[FieldBits-1]) begin
			r = r ^ ReducePoly;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/gf128m_operand_if.sv */
// gf128m_operand_if, gf128m_product_if: valid/ready request channels of the
// multiplier; no dependencies
`default_nettype none

interface gf128m_operand_if;
	logic        valid;
	logic        ready;
	logic [63:0] a_hi;
	logic [63:0] a_lo;
	logic [63:0] b_hi;
	logic [63:0] b_lo;

	modport source(output valid, a_hi, a_lo, b_hi, b_lo, input ready);
	modport sink(input valid, a_hi, a_lo, b_hi, b_lo, output ready);
endinterface

interface gf128m_product_if;
	logic        valid;
	logic        ready;
	logic [63:0] prod_hi;
	logic [63:0] prod_lo;

	modport source(output valid, prod_hi, prod_lo, input ready);
	modport sink(input valid, prod_hi, prod_lo, output ready);
endinterface

`default_nettype wire

/* rtl/gf128_multiplier_top.sv */
// gf128_multiplier_top: pipelined gf(2^128) multiplier, product reduced by
// x^128 + x^7 + x^2 + x + 1; depends on gf128m_pkg, gf128m_operand_if, gf128m_stage
//
// usage
//   operands: sink channel, one request carries a (a_hi, a_lo) and b (b_hi, b_lo),
//             plain big-endian bit order, bit 127 is the x^127 coefficient
//   product:  source channel, one request per operand request, in order,
//             prod_hi/prod_lo hold the reduced product a*b
//   a request is taken at a rising edge with valid and ready both high
// stages and throughput
//   FieldBits/STEP_BITS register stages (16 at the default of 8 bits a stage);
//   each stage runs STEP_BITS msb-first horner steps of a over b and
//   registers the result; the product leaves the last stage register
//   one request per cycle sustained while product.ready is high
// reset
//   arst_n clears every stage valid bit; payload registers are not reset
// stalls
//   when product.ready is low, the last stage holds its product; earlier
//   stages keep filling any empty slots, so operands.ready drops only
//   when every stage holds a request; nothing is lost or repeated
`default_nettype none

module gf128_multiplier_top #(
	// bits of a scanned per stage: 1, 2, 4, 8, 16, 32, 64 or 128
	parameter int unsigned STEP_BITS = gf128m_pkg::StepBitsDefault
) (
	input  wire                       clk,
	input  wire                       arst_n,
	gf128m_operand_if.sink            operands,
	gf128m_product_if.source          product
);

	localparam int unsigned NumStages = gf128m_pkg::FieldBits / STEP_BITS;

	// handshake chain, index 0 is the input side, NumStages the output side
	logic                    vld [0:NumStages];
	logic                    rdy [0:NumStages];
	gf128m_pkg::stage_data_t dat [0:NumStages];

	// accumulator starts at zero, a is scanned from bit 127
	assign vld[0]     = operands.valid;
	assign operands.ready = rdy[0];
	assign dat[0].a   = {operands.a_hi, operands.a_lo};
	assign dat[0].b   = {operands.b_hi, operands.b_lo};
	assign dat[0].acc = '0;

	for (genvar s = 0; s < NumStages; s++) begin : g_stage
		gf128m_stage #(
			.STEP_BITS (STEP_BITS)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[s]),
			.in_ready  (rdy[s]),
			.in_data   (dat[s]),
			.out_valid (vld[s+1]),
			.out_ready (rdy[s+1]),
			.out_data  (dat[s+1])
		);
	end

	// last stage register doubles as the output register
	assign product.valid   = vld[NumStages];
	assign rdy[NumStages]  = product.ready;
	assign product.prod_hi =
		dat[NumStages].acc[gf128m_pkg::FieldBits-1:gf128m_pkg::HalfBits];
	assign product.prod_lo = dat[NumStages].acc[gf128m_pkg::HalfBits-1:0];

endmodule

`default_nettype wire

/* rtl/gf128m_stage.sv */
// gf128m_stage: one pipeline stage, STEP_BITS horner steps then a register with
// its valid bit; depends on gf128m_pkg
`default_nettype none

module gf128m_stage #(
	parameter int unsigned STEP_BITS = gf128m_pkg::StepBitsDefault
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  gf128m_pkg::stage_data_t  in_data,
	output logic                     out_valid,
	input  wire                      out_ready,
	output gf128m_pkg::stage_data_t  out_data
);

	gf128m_pkg::stage_data_t nxt;
	gf128m_pkg::stage_data_t data_s1;
	logic                    valid_s1;

	// horner steps over the top bits of a
	always_comb begin
		nxt = in_data;
		for (int j = 0; j < STEP_BITS; j++) begin
			nxt.acc = gf128m_pkg::gf_double(nxt.acc);
			if (nxt.a[gf128m_pkg::FieldBits-1]) begin
				nxt.acc = nxt.acc ^ nxt.b;
			end
			nxt.a = {nxt.a[gf128m_pkg::FieldBits-2:0], 1'b0};
		end
	end

	// a stage takes a new request when empty or when its content moves on
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

`default_nettype wire

/* rtl/gf128m_checker.sv */
// gf128m_checker: port-level assertions for gf128_multiplier_top and the
// bind that attaches them; depends on gf128m_pkg
`default_nettype none

module gf128m_checker #(
	parameter int unsigned STAGES = gf128m_pkg::FieldBits / gf128m_pkg::StepBitsDefault
) (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [63:0] prod_hi,
	input wire [63:0] prod_lo
);

	localparam int unsigned CntBits = $clog2(STAGES + 1) + 1;

	logic [CntBits-1:0] cnt_q;
	logic               in_acc;
	logic               out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// requests inside the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   cnt_q <= cnt_q + CntBits'(1);
				2'b01:   cnt_q <= cnt_q - CntBits'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// a stalled product holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(prod_hi) && $stable(prod_lo))
		else $error("stalled product changed");

	// no product without a request inside
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != '0)
		else $error("product with no request in flight");

	// an empty slot anywhere means the input is open
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CntBits'(STAGES) |-> in_ready)
		else $error("input blocked with a free stage");

	// input closes only when full and stalled at the output
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready && cnt_q == CntBits'(STAGES))
		else $error("input blocked without an output stall");

endmodule

bind gf128_multiplier_top gf128m_checker #(
	.STAGES (NumStages)
) u_gf128m_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (operands.valid),
	.in_ready  (operands.ready),
	.out_valid (product.valid),
	.out_ready (product.ready),
	.prod_hi   (product.prod_hi),
	.prod_lo   (product.prod_lo)
);

`default_nettype wire
